### design/esds_descriptor_parser_macros.svh
// ----------------------------------------------------------------------------
// esds descriptor parser assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef ESDS_DESCRIPTOR_PARSER_MACROS_SVH
`define ESDS_DESCRIPTOR_PARSER_MACROS_SVH

// same-cycle implication
`define ESDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ESDS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/esds_pkg.sv
// ----------------------------------------------------------------------------
// esds descriptor parser package
// Transaction types and descriptor constants of the esds payload parser.
// ----------------------------------------------------------------------------
package esds_pkg;

   localparam int DEFAULT_MAX_LENGTH_BYTES = 4;

   localparam logic [7:0] TAG_ES  = 8'h03;
   localparam logic [7:0] TAG_DC  = 8'h04;
   localparam logic [7:0] TAG_DSI = 8'h05;

   localparam int LEN_MORE_BIT = 7;
   localparam int FLAG_DEP_BIT = 7;
   localparam int FLAG_URL_BIT = 6;
   localparam int FLAG_OCR_BIT = 5;

   localparam logic [7:0] ES_ID_SKIP   = 8'd2;
   localparam logic [7:0] FIELD_SKIP   = 8'd2;
   localparam logic [7:0] DC_REST_SKIP = 8'd12;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } esds_req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  object_type;
      logic        specific_info_present;
      logic [31:0] specific_info_offset;
      logic [27:0] specific_info_length;
   } esds_rsp_type;

endpackage

### design/esds_parse_core.sv
// ----------------------------------------------------------------------------
// esds parse core
// Byte-wide descriptor walk; one accepted byte updates the parse state.
// ----------------------------------------------------------------------------
module esds_parse_core #(
   parameter int MAX_LENGTH_BYTES = esds_pkg::DEFAULT_MAX_LENGTH_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  esds_pkg::esds_req_type req,
   output logic                  result_valid,
   output esds_pkg::esds_rsp_type result
);
   import esds_pkg::*;

   localparam int CntW = $clog2(MAX_LENGTH_BYTES + 1);

   typedef enum logic [3:0] {
      PH_ES_TAG, PH_ES_LEN, PH_ES_ID, PH_FLAGS, PH_DEP, PH_URL_LEN, PH_URL, PH_OCR,
      PH_DC_TAG, PH_DC_LEN, PH_OTI, PH_DC_REST, PH_DSI_TAG, PH_DSI_LEN, PH_DONE, PH_FAIL
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [31:0]      pos_ff, pos_in;
   logic [27:0]      acc_ff, acc_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [7:0]       skip_ff, skip_in;
   logic [7:0]       flags_ff, flags_in;
   logic [7:0]       obj_ff, obj_in;
   logic [31:0]      off_ff, off_in;
   logic [27:0]      ilen_ff, ilen_in;
   logic             fixed_ff, fixed_in;

   logic [7:0]       b;
   logic [27:0]      acc_next;
   logic [CntW-1:0]  cnt_next;
   logic             len_done, len_bad;
   logic [7:0]       skip_dec;
   logic             skip_end;
   phase_type        rt, ph;
   logic [32:0]      size;
   logic             ok, present;

   function automatic phase_type route(phase_type start, logic [7:0] fl);
      if (start == PH_DEP && fl[FLAG_DEP_BIT])
         return PH_DEP;
      if ((start == PH_DEP || start == PH_URL_LEN) && fl[FLAG_URL_BIT])
         return PH_URL_LEN;
      if (fl[FLAG_OCR_BIT])
         return PH_OCR;
      return PH_DC_TAG;
   endfunction

   always_comb begin
      b        = req.data_byte;
      acc_next = {acc_ff[20:0], b[6:0]};
      cnt_next = cnt_ff + CntW'(1);
      len_done = !b[LEN_MORE_BIT];
      len_bad  = b[LEN_MORE_BIT] && (cnt_next >= CntW'(MAX_LENGTH_BYTES));
      skip_dec = (skip_ff != 8'd0) ? skip_ff - 8'd1 : skip_ff;
      skip_end = (skip_dec == 8'd0);

      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      skip_in  = skip_ff;
      flags_in = flags_ff;
      obj_in   = obj_ff;
      off_in   = off_ff;
      ilen_in  = ilen_ff;
      fixed_in = fixed_ff;
      rt       = PH_DC_TAG;

      if (take && !fixed_ff) begin
         case (phase_ff)
            PH_ES_TAG, PH_DC_TAG: begin
               if (b == ((phase_ff == PH_ES_TAG) ? TAG_ES : TAG_DC)) begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = (phase_ff == PH_ES_TAG) ? PH_ES_LEN : PH_DC_LEN;
               end else begin
                  phase_in = PH_FAIL;
                  obj_in   = '0;
                  fixed_in = 1'b1;
               end
            end
            PH_ES_LEN, PH_DC_LEN: begin
               acc_in = acc_next;
               cnt_in = cnt_next;
               if (len_done) begin
                  if (phase_ff == PH_ES_LEN) begin
                     skip_in  = ES_ID_SKIP;
                     phase_in = PH_ES_ID;
                  end else begin
                     phase_in = PH_OTI;
                  end
               end else if (len_bad) begin
                  phase_in = PH_FAIL;
                  obj_in   = '0;
                  fixed_in = 1'b1;
               end
            end
            PH_ES_ID: begin
               skip_in = skip_dec;
               if (skip_end)
                  phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               flags_in = b;
               rt       = route(PH_DEP, b);
               phase_in = rt;
               if (rt == PH_DEP || rt == PH_OCR)
                  skip_in = FIELD_SKIP;
            end
            PH_DEP, PH_URL: begin
               skip_in = skip_dec;
               if (skip_end) begin
                  rt       = route((phase_ff == PH_DEP) ? PH_URL_LEN : PH_OCR, flags_ff);
                  phase_in = rt;
                  if (rt == PH_OCR)
                     skip_in = FIELD_SKIP;
               end
            end
            PH_URL_LEN: begin
               if (b == 8'd0) begin
                  rt       = route(PH_OCR, flags_ff);
                  phase_in = rt;
                  if (rt == PH_OCR)
                     skip_in = FIELD_SKIP;
               end else begin
                  skip_in  = b;
                  phase_in = PH_URL;
               end
            end
            PH_OCR: begin
               skip_in = skip_dec;
               if (skip_end)
                  phase_in = PH_DC_TAG;
            end
            PH_OTI: begin
               obj_in   = b;
               skip_in  = DC_REST_SKIP;
               phase_in = PH_DC_REST;
            end
            PH_DC_REST: begin
               skip_in = skip_dec;
               if (skip_end)
                  phase_in = PH_DSI_TAG;
            end
            PH_DSI_TAG: begin
               if (b == TAG_DSI) begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_DSI_LEN;
               end else begin
                  phase_in = PH_DONE;
                  fixed_in = 1'b1;
               end
            end
            PH_DSI_LEN: begin
               acc_in = acc_next;
               cnt_in = cnt_next;
               if (len_done) begin
                  off_in   = pos_ff + 32'd1;
                  ilen_in  = acc_next;
                  phase_in = PH_DONE;
                  fixed_in = 1'b1;
               end else if (len_bad) begin
                  ilen_in  = '0;
                  phase_in = PH_DONE;
                  fixed_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      ph      = phase_in;
      size    = {1'b0, pos_ff} + 33'd1;
      ok      = ph inside {PH_DSI_TAG, PH_DSI_LEN, PH_DONE};
      present = ok && (ph == PH_DONE) && (ilen_in != 28'd0) &&
                (({1'b0, off_in} + {5'd0, ilen_in}) <= size);

      result_valid                 = take && req.last_byte;
      result.status                = !ok;
      result.object_type           = ok ? obj_in : 8'd0;
      result.specific_info_present = present;
      result.specific_info_offset  = present ? off_in : 32'd0;
      result.specific_info_length  = present ? ilen_in : 28'd0;

      if (take) begin
         if (req.last_byte) begin
            phase_in = PH_ES_TAG;
            pos_in   = '0;
            acc_in   = '0;
            cnt_in   = '0;
            skip_in  = '0;
            flags_in = '0;
            obj_in   = '0;
            off_in   = '0;
            ilen_in  = '0;
            fixed_in = 1'b0;
         end else if (pos_ff != 32'hFFFF_FFFF) begin
            pos_in = pos_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ES_TAG;
         pos_ff   <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         skip_ff  <= '0;
         flags_ff <= '0;
         obj_ff   <= '0;
         off_ff   <= '0;
         ilen_ff  <= '0;
         fixed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         skip_ff  <= skip_in;
         flags_ff <= flags_in;
         obj_ff   <= obj_in;
         off_ff   <= off_in;
         ilen_ff  <= ilen_in;
         fixed_ff <= fixed_in;
      end
   end

endmodule

### design/esds_descriptor_parser.sv
// ----------------------------------------------------------------------------
// esds descriptor parser
// Streams an esds payload and reports the decoder configuration summary.
// ----------------------------------------------------------------------------
// One payload byte is accepted per cycle while req_stall is low; each byte
// advances the parse state. The result of a payload appears in the output
// register in the cycle after its last byte is accepted, and the next payload
// may start in the following cycle. The input stalls only while a result is
// held in the output register and rsp_stall is high.
module esds_descriptor_parser #(
   parameter int MAX_LENGTH_BYTES = esds_pkg::DEFAULT_MAX_LENGTH_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  esds_pkg::esds_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output esds_pkg::esds_rsp_type rsp_data
);
   import esds_pkg::*;

   logic         accept;
   logic         result_valid;
   esds_rsp_type result;
   logic         rsp_valid_ff, rsp_valid_in;
   esds_rsp_type rsp_data_ff, rsp_data_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   esds_parse_core #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (accept),
      .req         (req_data),
      .result_valid(result_valid),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/esds_checker.sv
// ----------------------------------------------------------------------------
// esds descriptor parser checker
// Port-level assertions on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "esds_descriptor_parser_macros.svh"

module esds_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input esds_pkg::esds_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input esds_pkg::esds_rsp_type rsp_data
);
   import esds_pkg::*;

   `ESDS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `ESDS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a blocked response")
   `ESDS_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_data.last_byte), "response without a last byte")
   `ESDS_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_data.status, rsp_data.object_type == 8'd0 && !rsp_data.specific_info_present, "failed parse with data")
   `ESDS_ASSERT_NOW(a_info_len, clock, reset, rsp_valid && rsp_data.specific_info_present, rsp_data.specific_info_length != 28'd0 && !rsp_data.status, "empty specific info reported")

endmodule

bind esds_descriptor_parser esds_checker u_checker (.*);

### tb/esds_payload_check_pkg.sv
// ----------------------------------------------------------------------------
// esds payload scoreboard
// Tracks the descriptor walk of each esds payload byte by byte and checks
// every parser summary against the predicted one, in order.
// ----------------------------------------------------------------------------
package esds_payload_check_pkg;

   import esds_pkg::*;

   typedef enum logic [3:0] {
      PS_ES_TAG, PS_ES_LEN, PS_ES_ID, PS_FLAGS, PS_DEP, PS_URL_LEN, PS_URL, PS_OCR,
      PS_DC_TAG, PS_DC_LEN, PS_OTI, PS_DC_REST, PS_DSI_TAG, PS_DSI_LEN, PS_DONE,
      PS_FAIL
   } parse_phase_type;

   typedef enum {FIELD_OPEN, FIELD_CLOSED, FIELD_OVERRUN} length_field_type;

   class esds_payload_scoreboard;
      parse_phase_type phase;
      logic [31:0]  position;
      logic [27:0]  len_acc;
      logic [2:0]   len_count;
      logic [8:0]   skip_left;
      logic [7:0]   flags;
      logic [7:0]   object_type;
      logic [31:0]  info_at;
      logic [27:0]  info_len;
      bit           settled;
      int           max_len_bytes;
      esds_rsp_type summary_q[$];
      int unsigned  mismatches;

      function new(int max_len);
         max_len_bytes = max_len;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase = PS_ES_TAG;
         position = '0;
         len_acc = '0;
         len_count = '0;
         skip_left = '0;
         flags = '0;
         object_type = '0;
         info_at = '0;
         info_len = '0;
         settled = 1'b0;
      endfunction

      function void start_length(parse_phase_type next);
         len_acc = '0;
         len_count = '0;
         phase = next;
      endfunction

      function length_field_type take_length(logic [7:0] b);
         len_acc = {len_acc[20:0], b[6:0]};
         len_count = len_count + 3'd1;
         if (!b[LEN_MORE_BIT]) return FIELD_CLOSED;
         if (int'(len_count) >= max_len_bytes) return FIELD_OVERRUN;
         return FIELD_OPEN;
      endfunction

      function void abort();
         phase = PS_FAIL;
         object_type = '0;
         settled = 1'b1;
      endfunction

      function parse_phase_type next_field(parse_phase_type from);
         if (from == PS_DEP) begin
            if (flags[FLAG_DEP_BIT]) begin
               skip_left = {1'b0, FIELD_SKIP};
               return PS_DEP;
            end
            from = PS_URL_LEN;
         end
         if (from == PS_URL_LEN) begin
            if (flags[FLAG_URL_BIT]) return PS_URL_LEN;
            from = PS_OCR;
         end
         if (from == PS_OCR && flags[FLAG_OCR_BIT]) begin
            skip_left = {1'b0, FIELD_SKIP};
            return PS_OCR;
         end
         return PS_DC_TAG;
      endfunction

      function bit skip_done();
         if (skip_left != 0) skip_left = skip_left - 9'd1;
         return skip_left == 0;
      endfunction

      function void advance(logic [7:0] b);
         length_field_type r;
         case (phase)
            PS_ES_TAG: begin
               if (b == TAG_ES) start_length(PS_ES_LEN);
               else abort();
            end
            PS_ES_LEN: begin
               r = take_length(b);
               if (r == FIELD_CLOSED) begin
                  skip_left = {1'b0, ES_ID_SKIP};
                  phase = PS_ES_ID;
               end else if (r == FIELD_OVERRUN) begin
                  abort();
               end
            end
            PS_ES_ID: begin
               if (skip_done()) phase = PS_FLAGS;
            end
            PS_FLAGS: begin
               flags = b;
               phase = next_field(PS_DEP);
            end
            PS_DEP: begin
               if (skip_done()) phase = next_field(PS_URL_LEN);
            end
            PS_URL_LEN: begin
               if (b == 8'd0) begin
                  phase = next_field(PS_OCR);
               end else begin
                  skip_left = {1'b0, b};
                  phase = PS_URL;
               end
            end
            PS_URL: begin
               if (skip_done()) phase = next_field(PS_OCR);
            end
            PS_OCR: begin
               if (skip_done()) phase = PS_DC_TAG;
            end
            PS_DC_TAG: begin
               if (b == TAG_DC) start_length(PS_DC_LEN);
               else abort();
            end
            PS_DC_LEN: begin
               r = take_length(b);
               if (r == FIELD_CLOSED) phase = PS_OTI;
               else if (r == FIELD_OVERRUN) abort();
            end
            PS_OTI: begin
               object_type = b;
               skip_left = {1'b0, DC_REST_SKIP};
               phase = PS_DC_REST;
            end
            PS_DC_REST: begin
               if (skip_done()) phase = PS_DSI_TAG;
            end
            PS_DSI_TAG: begin
               if (b == TAG_DSI) begin
                  start_length(PS_DSI_LEN);
               end else begin
                  phase = PS_DONE;
                  settled = 1'b1;
               end
            end
            PS_DSI_LEN: begin
               r = take_length(b);
               if (r == FIELD_CLOSED) begin
                  info_at = position + 32'd1;
                  info_len = len_acc;
                  phase = PS_DONE;
                  settled = 1'b1;
               end else if (r == FIELD_OVERRUN) begin
                  info_len = '0;
                  phase = PS_DONE;
                  settled = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void note_byte(esds_req_type t);
         esds_rsp_type e;
         logic [32:0]  size;
         bit           ok;
         bit           present;
         if (!settled) advance(t.data_byte);
         if (!t.last_byte) begin
            if (position != '1) position = position + 32'd1;
            return;
         end
         size = {1'b0, position} + 33'd1;
         ok = (phase == PS_DSI_TAG) || (phase == PS_DSI_LEN) || (phase == PS_DONE);
         present = ok && phase == PS_DONE && info_len != 0 &&
                   ({1'b0, info_at} + {5'd0, info_len}) <= size;
         e.status = !ok;
         e.object_type = ok ? object_type : 8'd0;
         e.specific_info_present = present;
         e.specific_info_offset = present ? info_at : 32'd0;
         e.specific_info_length = present ? info_len : 28'd0;
         summary_q.push_back(e);
         restart();
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] seen);
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
         mismatches++;
      endfunction

      function void check_result(esds_rsp_type got);
         esds_rsp_type e;
         if (summary_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         e = summary_q.pop_front();
         if (got.status !== e.status)
            report("status", 32'(e.status), 32'(got.status));
         if (got.object_type !== e.object_type)
            report("object_type", 32'(e.object_type), 32'(got.object_type));
         if (got.specific_info_present !== e.specific_info_present)
            report("specific_info_present", 32'(e.specific_info_present),
                   32'(got.specific_info_present));
         if (got.specific_info_offset !== e.specific_info_offset)
            report("specific_info_offset", e.specific_info_offset, got.specific_info_offset);
         if (got.specific_info_length !== e.specific_info_length)
            report("specific_info_length", 32'(e.specific_info_length),
                   32'(got.specific_info_length));
      endfunction

      function int unsigned pending();
         return summary_q.size();
      endfunction
   endclass

endpackage

### tb/tb_esds_descriptor_parser.sv
// ----------------------------------------------------------------------------
// esds descriptor parser testbench
// Streams directed and randomized esds payloads, well-formed, truncated and
// corrupted, under random gaps and stalls on both channels, and compares each
// summary with a byte-level prediction of the descriptor walk.
// ----------------------------------------------------------------------------
module tb_esds_descriptor_parser;

   timeunit 1ns;
   timeprecision 1ps;

   import esds_pkg::*;
   import esds_payload_check_pkg::*;

   localparam int LEN_FIELD_MAX = DEFAULT_MAX_LENGTH_BYTES;

   typedef enum {INFO_NONE, INFO_FULL, INFO_SHORT, INFO_BAD_LEN, INFO_OTHER_TAG} info_shape_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   esds_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   esds_rsp_type rsp_data;

   esds_payload_scoreboard sb = new(LEN_FIELD_MAX);

   logic [7:0]  payload_q[$];
   int unsigned bytes_sent;
   int unsigned payloads_sent;
   bit          send_calm;
   bit          take_calm;

   esds_descriptor_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void push_random(int unsigned n);
      repeat (n) payload_q.push_back(8'($urandom));
   endfunction

   function automatic void push_length(int unsigned value, int unsigned groups);
      for (int i = int'(groups) - 1; i >= 0; i--)
         payload_q.push_back(8'((value >> (7 * i)) & 32'h7F) | ((i > 0) ? 8'h80 : 8'h00));
   endfunction

   function automatic void push_any_length();
      int unsigned groups;
      groups = $urandom_range(1, LEN_FIELD_MAX);
      push_length($urandom & ((32'd1 << (7 * groups)) - 1), groups);
   endfunction

   function automatic void push_info_length(int unsigned value);
      int unsigned groups;
      groups = 1;
      while (groups < LEN_FIELD_MAX && (value >> (7 * groups)) != 0) groups++;
      push_length(value, $urandom_range(groups, LEN_FIELD_MAX));
   endfunction

   function automatic void push_overrun();
      repeat (LEN_FIELD_MAX) payload_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
   endfunction

   function automatic void build_payload(logic [7:0] flags, int unsigned url_len,
                                         logic [7:0] oti, info_shape_type shape,
                                         int unsigned info_len, int unsigned tail,
                                         bit dc_overrun);
      int unsigned body;
      payload_q.delete();
      payload_q.push_back(TAG_ES);
      push_any_length();
      push_random(2);
      payload_q.push_back(flags);
      if (flags[FLAG_DEP_BIT]) push_random(2);
      if (flags[FLAG_URL_BIT]) begin
         payload_q.push_back(8'(url_len));
         push_random(url_len);
      end
      if (flags[FLAG_OCR_BIT]) push_random(2);
      payload_q.push_back(TAG_DC);
      if (dc_overrun) push_overrun();
      else push_any_length();
      payload_q.push_back(oti);
      push_random(12);
      case (shape)
         INFO_FULL: begin
            payload_q.push_back(TAG_DSI);
            push_info_length(info_len);
            push_random(info_len);
         end
         INFO_SHORT: begin
            payload_q.push_back(TAG_DSI);
            push_info_length(info_len);
            body = (info_len > 20) ? 20 : info_len;
            push_random((body > 0) ? $urandom_range(0, body - 1) : 0);
         end
         INFO_BAD_LEN: begin
            payload_q.push_back(TAG_DSI);
            push_overrun();
         end
         INFO_OTHER_TAG: begin
            payload_q.push_back(8'($urandom_range(0, 3)) == 8'd0 ? 8'hFF : 8'h06);
         end
         default: ;
      endcase
      push_random(tail);
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      esds_req_type t;
      int unsigned  gap;
      gap = send_calm ? 0 : $urandom_range(0, 9);
      t.data_byte = b;
      t.last_byte = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      sb.note_byte(t);
      bytes_sent++;
   endtask

   task automatic send_payload();
      send_calm = ($urandom_range(0, 3) == 0);
      foreach (payload_q[i]) send_byte(payload_q[i], i == payload_q.size() - 1);
      payloads_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic random_payload();
      logic [7:0]  flags;
      int unsigned url_len;
      int unsigned info_len;
      int unsigned roll;
      info_shape_type shape;
      flags = 8'($urandom);
      roll = $urandom_range(0, 99);
      url_len = (roll < 4) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      roll = $urandom_range(0, 99);
      if (roll < 40) shape = INFO_FULL;
      else if (roll < 55) shape = INFO_NONE;
      else if (roll < 70) shape = INFO_SHORT;
      else if (roll < 85) shape = INFO_BAD_LEN;
      else shape = INFO_OTHER_TAG;
      roll = $urandom_range(0, 9);
      if (shape == INFO_SHORT)
         info_len = (roll < 5) ? $urandom_range(1, 40) : ($urandom & 32'h0FFF_FFFF);
      else
         info_len = (roll == 0) ? 0 : $urandom_range(1, 16);
      build_payload(flags, url_len, 8'($urandom), shape, info_len,
                    ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0,
                    $urandom_range(0, 19) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         payload_q = payload_q[0 : $urandom_range(0, payload_q.size() - 1)];
      end else if (roll < 25) begin
         payload_q[$urandom_range(0, payload_q.size() - 1)] = 8'($urandom);
      end else if (roll < 33) begin
         payload_q.delete();
         if ($urandom_range(0, 1) == 1) payload_q.push_back(TAG_ES);
         push_random($urandom_range(1, 30));
      end else if (roll < 37) begin
         payload_q = '{TAG_ES};
         push_overrun();
         push_random($urandom_range(0, 5));
      end
   endtask

   initial begin
      int unsigned hold;
      bit          taken;
      esds_rsp_type got;
      hold = 0;
      take_calm = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         taken = !reset && rsp_valid === 1'b1 && rsp_stall === 1'b0;
         got = rsp_data;
         @(posedge clock);
         if (taken) begin
            sb.check_result(got);
            if ($urandom_range(0, 9) == 0) take_calm = !take_calm;
            hold = take_calm ? 0 : $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      bytes_sent = 0;
      payloads_sent = 0;
      send_calm = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      payload_q = '{TAG_ES};
      send_payload();
      payload_q = '{8'h00, 8'hFF, TAG_ES};
      send_payload();
      build_payload(8'h00, 0, 8'hFF, INFO_NONE, 0, 0, 1'b0);
      send_payload();
      build_payload(8'hE0, 0, 8'h40, INFO_FULL, 5, 0, 1'b0);
      send_payload();
      build_payload(8'hFF, 3, 8'h00, INFO_FULL, 0, 2, 1'b0);
      send_payload();
      build_payload(8'h20, 0, 8'h6B, INFO_SHORT, 32'h0FFF_FFFF, 0, 1'b0);
      send_payload();
      build_payload(8'h40, 2, 8'h69, INFO_BAD_LEN, 0, 0, 1'b0);
      send_payload();
      build_payload(8'h40, 2, 8'h69, INFO_BAD_LEN, 0, 0, 1'b0);
      void'(payload_q.pop_back());
      send_payload();
      build_payload(8'h80, 0, 8'h11, INFO_OTHER_TAG, 0, 3, 1'b0);
      send_payload();
      build_payload(8'h00, 0, 8'h40, INFO_NONE, 0, 0, 1'b1);
      send_payload();
      payload_q = '{TAG_ES};
      push_overrun();
      payload_q.push_back(8'h00);
      send_payload();
      build_payload(8'h40, 200, 8'h40, INFO_NONE, 0, 0, 1'b0);
      payload_q = payload_q[0 : 19];
      send_payload();
      build_payload(8'h00, 0, 8'h40, INFO_NONE, 0, 0, 1'b0);
      void'(payload_q.pop_back());
      send_payload();
      payload_q = '{TAG_ES, 8'h00, 8'h12, 8'h34, 8'h00, 8'h07, TAG_DC};
      send_payload();
      drain();

      while (bytes_sent < 750) begin
         if (payloads_sent % 16 == 0) drain();
         random_payload();
         send_payload();
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
